// ----- rtl/lattice_boundary_link_mask_assert.svh -----
// Assertion macros for the lattice boundary link mask block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef LATTICE_BOUNDARY_LINK_MASK_ASSERT_SVH
`define LATTICE_BOUNDARY_LINK_MASK_ASSERT_SVH
`ifndef SYNTHESIS
`define LBLM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LBLM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LBLM_ASSERT(lbl, clk, rst, prop, msg)
`define LBLM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/lblm_pkg.sv -----
// Shared types, codes and helpers for the lattice boundary link mask block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package lblm_pkg;

  localparam int MAX_DIM_DEF = 32;
  localparam int COORD_LIM   = 32;   // reach of a 5-bit coordinate
  localparam int COORD_W     = 5;
  localparam int SIZE_W      = 6;
  localparam int LINK_W      = 14;
  localparam int CFG_IDX_W   = 2;
  localparam int STEP_W      = 4;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = 1;
  localparam int Q_CNT_W     = 2;

  localparam logic [STEP_W-1:0] LAST_STEP = 4'd14;   // center + 14 neighbors
  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
    logic               solid;
  } in_item_t;

  typedef struct packed {
    logic [LINK_W-1:0] link_mask;
    logic              range_error;
  } out_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0] sx;
    logic [SIZE_W-1:0] sy;
    logic [SIZE_W-1:0] sz;
  } lat_size_t;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_QUERY  = 2'd1,
    OP_REJECT = 2'd2
  } cmd_op_t;

  // classified command passed from front to back through the queue
  typedef struct packed {
    cmd_op_t            op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] xp;
    logic [COORD_W-1:0] xm;
    logic [COORD_W-1:0] yp;
    logic [COORD_W-1:0] ym;
    logic [COORD_W-1:0] zp;
    logic [COORD_W-1:0] zm;
    logic               solid;
  } cmd_t;

  typedef enum logic [1:0] {
    AX_C = 2'd0,
    AX_P = 2'd1,
    AX_M = 2'd2
  } axis_sel_t;

  typedef struct packed {
    axis_sel_t sx;
    axis_sel_t sy;
    axis_sel_t sz;
  } dir_t;

  typedef enum logic [2:0] {
    BK_CLEAR  = 3'd0,
    BK_IDLE   = 3'd1,
    BK_READ   = 3'd2,
    BK_WAIT   = 3'd3,
    BK_FINISH = 3'd4
  } bk_state_t;

  // Read step to neighbor offset. Step 0 is the node itself, step k is
  // mask bit k-1.
  function automatic dir_t dir_sel(input logic [STEP_W-1:0] step);
    dir_t d;
    d = '{AX_C, AX_C, AX_C};
    case (step)
      4'd1:  d = '{AX_P, AX_C, AX_C};
      4'd2:  d = '{AX_M, AX_C, AX_C};
      4'd3:  d = '{AX_C, AX_P, AX_C};
      4'd4:  d = '{AX_C, AX_M, AX_C};
      4'd5:  d = '{AX_C, AX_C, AX_P};
      4'd6:  d = '{AX_C, AX_C, AX_M};
      4'd7:  d = '{AX_P, AX_P, AX_P};
      4'd8:  d = '{AX_M, AX_P, AX_P};
      4'd9:  d = '{AX_P, AX_M, AX_P};
      4'd10: d = '{AX_M, AX_M, AX_P};
      4'd11: d = '{AX_P, AX_P, AX_M};
      4'd12: d = '{AX_M, AX_P, AX_M};
      4'd13: d = '{AX_P, AX_M, AX_M};
      4'd14: d = '{AX_M, AX_M, AX_M};
      default: d = '{AX_C, AX_C, AX_C};
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/lblm_front.sv -----
// Front end: accepts items, range-checks them and works out wrapped
// neighbor coordinates. Depends on lblm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lblm_front #(
  parameter int MAX_DIM = lblm_pkg::MAX_DIM_DEF
) (
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire lblm_pkg::in_item_t in_item,
  input  wire lblm_pkg::lat_size_t sizes,
  input  wire logic               clearing,
  input  wire logic               q_full,
  output logic                    push,
  output lblm_pkg::cmd_t          cmd
);
  import lblm_pkg::*;

  localparam int LIM = (MAX_DIM < COORD_LIM) ? MAX_DIM : COORD_LIM;
  localparam logic [SIZE_W-1:0] LIM_S = SIZE_W'(LIM);

  logic [SIZE_W-1:0] nx, ny, nz;
  logic              ok;
  logic              accept;

  function automatic logic [SIZE_W-1:0] clamp(input logic [SIZE_W-1:0] v);
    return (v > LIM_S) ? LIM_S : v;
  endfunction

  function automatic logic [COORD_W-1:0] up(input logic [COORD_W-1:0] c,
                                            input logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] s;
    s = {1'b0, c} + 6'd1;
    return (s >= n) ? '0 : s[COORD_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] down(input logic [COORD_W-1:0] c,
                                              input logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] s;
    s = n - 6'd1;
    return (c == '0) ? s[COORD_W-1:0] : c - 5'd1;
  endfunction

  assign nx = clamp(sizes.sx);
  assign ny = clamp(sizes.sy);
  assign nz = clamp(sizes.sz);
  assign ok = ({1'b0, in_item.coord_x} < nx) && ({1'b0, in_item.coord_y} < ny) &&
              ({1'b0, in_item.coord_z} < nz);

  // stalled in reset, through the back end's clearing sweep and while the queue is full
  assign in_stall = clearing || q_full || rst;
  assign accept   = in_valid && !in_stall;

  // out-of-range writes are taken and dropped here
  assign push = accept && (ok || in_item.kind == KIND_QUERY);

  always_comb begin
    cmd.x     = in_item.coord_x;
    cmd.y     = in_item.coord_y;
    cmd.z     = in_item.coord_z;
    cmd.xp    = up(in_item.coord_x, nx);
    cmd.xm    = down(in_item.coord_x, nx);
    cmd.yp    = up(in_item.coord_y, ny);
    cmd.ym    = down(in_item.coord_y, ny);
    cmd.zp    = up(in_item.coord_z, nz);
    cmd.zm    = down(in_item.coord_z, nz);
    cmd.solid = in_item.solid;
    if (in_item.kind == KIND_WRITE) begin
      cmd.op = OP_WRITE;
    end else if (ok) begin
      cmd.op = OP_QUERY;
    end else begin
      cmd.op = OP_REJECT;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lblm_fifo.sv -----
// Two-entry command queue between the front and back ends.
// Depends on lblm_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none
module lblm_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire lblm_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output lblm_pkg::cmd_t      head,
  output logic                not_empty
);
  import lblm_pkg::*;

  cmd_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] cnt;

  assign full      = (cnt == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (cnt != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lblm_back.sv -----
// Back end: occupancy memory, clearing pass, neighbor read sequencer and
// the result register. Depends on lblm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "lattice_boundary_link_mask_assert.svh"
module lblm_back #(
  parameter int MAX_DIM = lblm_pkg::MAX_DIM_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire lblm_pkg::cmd_t cmd,
  input  wire logic           cmd_valid,
  output logic                cmd_pop,
  output logic                clearing,
  output logic                out_valid,
  input  wire logic           out_stall,
  output lblm_pkg::out_item_t out_item
);
  import lblm_pkg::*;

  localparam int LIM    = (MAX_DIM < COORD_LIM) ? MAX_DIM : COORD_LIM;
  localparam int DEPTH  = LIM * LIM * LIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] ROW_Z     = ADDR_W'(LIM);
  localparam logic [ADDR_W-1:0] ROW_YZ    = ADDR_W'(LIM * LIM);

  bk_state_t          st, st_next;
  logic [ADDR_W-1:0]  clr_addr;
  cmd_t               cur;
  logic [STEP_W-1:0]  step;
  logic               rd_valid_q;
  logic [STEP_W-1:0]  rd_step_q;
  logic               center;
  logic [LINK_W-1:0]  fluid;
  logic               rd_data;
  logic               mem [DEPTH];

  logic               mem_we;
  logic               mem_wd;
  logic [ADDR_W-1:0]  mem_addr;
  logic [COORD_W-1:0] ax, ay, az;
  logic               out_load;
  dir_t               dir;

  function automatic logic [COORD_W-1:0] pick(input axis_sel_t s,
                                              input logic [COORD_W-1:0] c,
                                              input logic [COORD_W-1:0] p,
                                              input logic [COORD_W-1:0] m);
    logic [COORD_W-1:0] r;
    case (s)
      AX_P:    r = p;
      AX_M:    r = m;
      default: r = c;
    endcase
    return r;
  endfunction

  assign clearing = (st == BK_CLEAR);
  assign dir      = dir_sel(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= BK_CLEAR;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next  = st;
    cmd_pop  = 1'b0;
    mem_we   = 1'b0;
    mem_wd   = 1'b0;
    out_load = 1'b0;
    ax = pick(dir.sx, cur.x, cur.xp, cur.xm);
    ay = pick(dir.sy, cur.y, cur.yp, cur.ym);
    az = pick(dir.sz, cur.z, cur.zp, cur.zm);
    case (st)
      BK_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == LAST_ADDR) begin
          st_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        ax = cmd.x;
        ay = cmd.y;
        az = cmd.z;
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_WRITE: begin
              mem_we = 1'b1;
              mem_wd = cmd.solid;
            end
            OP_QUERY:  st_next = BK_READ;
            OP_REJECT: st_next = BK_FINISH;
            default:   st_next = BK_IDLE;
          endcase
        end
      end
      BK_READ: begin
        if (step == LAST_STEP) begin
          st_next = BK_WAIT;
        end
      end
      BK_WAIT: st_next = BK_FINISH;
      BK_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          st_next  = BK_IDLE;
        end
      end
      default: st_next = BK_IDLE;
    endcase
    if (st == BK_CLEAR) begin
      mem_addr = clr_addr;
    end else begin
      mem_addr = ADDR_W'(ax) * ROW_YZ + ADDR_W'(ay) * ROW_Z + ADDR_W'(az);
    end
  end

  // single-port occupancy store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    rd_data <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      step       <= '0;
      rd_valid_q <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (st == BK_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (st == BK_READ) begin
        step <= step + 1'b1;
      end else begin
        step <= '0;
      end
      rd_valid_q <= (st == BK_READ);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_step_q <= step;
    if (cmd_pop) begin
      cur <= cmd;
    end
    if (rd_valid_q) begin
      if (rd_step_q == '0) begin
        center <= rd_data;
      end else begin
        fluid[STEP_W'(rd_step_q - 1'b1)] <= !rd_data;
      end
    end
    if (out_load) begin
      out_item.range_error <= (cur.op == OP_REJECT);
      if (cur.op == OP_REJECT || !center) begin
        out_item.link_mask <= '0;
      end else begin
        out_item.link_mask <= fluid;
      end
    end
  end

  `LBLM_ASSERT_ALWAYS(a_rst_clear, clk, rst |=> (st == BK_CLEAR && !out_valid), "reset did not start clear")
  `LBLM_ASSERT(a_no_pop_clear, clk, rst, (st == BK_CLEAR) |-> !cmd_pop, "command taken while clearing")
  `LBLM_ASSERT(a_rd_in_query, clk, rst, rd_valid_q |-> $past(st == BK_READ), "stray read data capture")
  `LBLM_ASSERT(a_out_from_fin, clk, rst, $rose(out_valid) |-> $past(st == BK_FINISH), "result outside finish")
  `LBLM_ASSERT(a_err_zero, clk, rst, (out_valid && out_item.range_error) |-> (out_item.link_mask == '0), "range error with mask")

endmodule
`default_nettype wire

// ----- rtl/lattice_boundary_link_mask.sv -----
// Lattice boundary link mask: D3Q15 link mask of a solid/fluid lattice with
// periodic wrap. Items enter through a classifying front end and a two-entry
// queue; a back end with a single-port occupancy memory does the work: a
// write is done as the command is taken, and a query takes the command,
// makes 15 memory reads of the node and its fourteen neighbors at one read
// per cycle, waits out the registered read, then loads the result register.
// A query whose coordinate lies outside the configured size goes from
// taking the command straight to loading the result and returns a zero
// mask with range_error set; an out-of-range write is dropped at the front.
// After reset the memory is swept to all fluid, one node per cycle, over
// all MAX_DIM cubed nodes (32768 at the default, capped at 32 nodes per
// axis); the input is stalled during the sweep while size registers can
// still be written. The user must write size registers only while the
// block has no item in flight; the block itself does not enforce this.
// Depends on lblm_pkg, lblm_front, lblm_fifo and lblm_back.
`timescale 1ns / 1ps
`default_nettype none
module lattice_boundary_link_mask #(
  parameter int MAX_DIM = lblm_pkg::MAX_DIM_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // input items
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire lblm_pkg::in_item_t                in_item,
  // result items
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output lblm_pkg::out_item_t                    out_item,
  // size register writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [lblm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lblm_pkg::SIZE_W-1:0]       cfg_data
);
  import lblm_pkg::*;

  lat_size_t sizes;
  logic      clearing;
  logic      q_full;
  logic      q_push;
  cmd_t      q_in;
  cmd_t      q_head;
  logic      q_not_empty;
  logic      q_pop;

  // registers are always writable, also during the clearing sweep
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sizes.sx <= SIZE_RESET;
      sizes.sy <= SIZE_RESET;
      sizes.sz <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SIZE_X: sizes.sx <= cfg_data;
        REG_SIZE_Y: sizes.sy <= cfg_data;
        REG_SIZE_Z: sizes.sz <= cfg_data;
        default:    sizes    <= sizes;   // no register at this index
      endcase
    end
  end

  // classify: range check, wrapped neighbor coordinates
  lblm_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .sizes    (sizes),
    .clearing (clearing),
    .q_full   (q_full),
    .push     (q_push),
    .cmd      (q_in)
  );

  // decouples the input handshake from the read sequencer
  lblm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty)
  );

  // memory, clear sweep, neighbor reads, result register
  lblm_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (q_head),
    .cmd_valid (q_not_empty),
    .cmd_pop   (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
